/* design/atod_pkg.sv */
// shared types and constants of the audio transient onset detector
package atod_pkg;

  localparam int unsigned APB_ADDR_BITS = 5;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned ENV_BITS      = 32;
  localparam int unsigned THR_BITS      = 24;
  localparam int unsigned THR_FRAC      = 16;
  localparam int unsigned COOL_BITS     = 24;
  localparam int unsigned MUL_OP_BITS   = 33;
  localparam int unsigned MUL_RES_BITS  = 2 * MUL_OP_BITS;

  localparam logic [31:0] ATTACK_RST   = 32'd16729728;
  localparam logic [31:0] RELEASE_RST  = 32'd16775694;
  localparam logic [31:0] THRESHOLD_RST = 32'd207243;
  localparam logic [31:0] GATE_RST     = 32'd125829;
  localparam logic [31:0] COOLDOWN_RST = 32'd6615;

  typedef enum logic [2:0] {
    REG_ATTACK    = 3'd0,
    REG_RELEASE   = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_GATE      = 3'd3,
    REG_COOLDOWN  = 3'd4
  } reg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_MUL1   = 6'b000100,
    ST_ENV    = 6'b001000,
    ST_MUL2   = 6'b010000,
    ST_DECIDE = 6'b100000
  } state_e;

  typedef struct packed {
    logic                           en;
    logic signed [MUL_OP_BITS-1:0]  a;
    logic signed [MUL_OP_BITS-1:0]  b;
  } mul_req_t;

endpackage

/* design/atod_mul.sv */
// shared signed multiplier with registered product
module atod_mul
  import atod_pkg::*;
(
  input  logic                           clk_i,
  input  mul_req_t                       req_i,
  output logic signed [MUL_RES_BITS-1:0] prod_o
);

  logic signed [MUL_RES_BITS-1:0] prod_q;
  logic signed [MUL_RES_BITS-1:0] prod_d;

  always_comb begin
    prod_d = prod_q;
    if (req_i.en) begin
      prod_d = MUL_RES_BITS'(req_i.a) * MUL_RES_BITS'(req_i.b);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

/* design/audio_transient_onset_detector.sv */
// top level of the audio transient onset detector
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i / in_stall_o  sample_i, frame_end_i
//   out       source     out_valid_o / out_stall_i trigger_o, frame_index_o, envelope_level_o
//   config    apb slave  psel, penable, pready    paddr, pwdata, prdata
//
// an item without frame_end is taken in idle; a frame_end item passes setup, mul1, env, mul2
// and decide, making two passes through the one shared multiplier (envelope, then threshold)
// a result waits in the output register while the next frame's items are taken;
// the next frame end holds in its decide step until that result is gone
// async active-low reset loads register defaults; clears all but operand and payload regs
module audio_transient_onset_detector
  import atod_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned COEF_BITS   = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          trigger_o,
  output logic [ENV_BITS-1:0]           frame_index_o,
  output logic [ENV_BITS-1:0]           envelope_level_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_BITS-1:0]      paddr,
  input  logic [APB_DATA_BITS-1:0]      pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  localparam int unsigned ENV_SHIFT = ENV_BITS - SAMPLE_BITS;
  localparam logic signed [MUL_RES_BITS-1:0] ROUND_HALF =
    MUL_RES_BITS'(1) << (COEF_BITS - 1);

  logic [COEF_BITS-1:0]   attack_q, release_q;
  logic [THR_BITS-1:0]    thresh_q;
  logic [SAMPLE_BITS-1:0] gate_q;
  logic [COOL_BITS-1:0]   cool_q;

  state_e                 state_q, state_d;
  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [ENV_BITS-1:0]    env_q, env_d;
  logic [ENV_BITS-1:0]    frame_cnt_q, frame_cnt_d;
  logic [ENV_BITS-1:0]    last_onset_q, last_onset_d;
  logic                   seen_q, seen_d;
  logic signed [MUL_OP_BITS-1:0] opa_q, opa_d, opb_q, opb_d;

  logic                   out_valid_q, out_valid_d;
  logic                   trigger_q, trigger_d;
  logic [ENV_BITS-1:0]    idx_out_q, idx_out_d;
  logic [ENV_BITS-1:0]    env_out_q, env_out_d;

  logic                   cfg_wr;
  reg_idx_e               cfg_idx;
  logic                   in_acc;
  logic [SAMPLE_BITS-1:0] mag, peak_new;
  logic [ENV_BITS-1:0]    p_val, env_new, onset_gap;
  logic signed [MUL_RES_BITS-1:0] prod, rounded, shifted;
  logic                   can_emit, onset;
  mul_req_t               mul_req;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[APB_ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= COEF_BITS'(ATTACK_RST);
      release_q <= COEF_BITS'(RELEASE_RST);
      thresh_q  <= THR_BITS'(THRESHOLD_RST);
      gate_q    <= SAMPLE_BITS'(GATE_RST);
      cool_q    <= COOL_BITS'(COOLDOWN_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ATTACK:    attack_q  <= pwdata[COEF_BITS-1:0];
        REG_RELEASE:   release_q <= pwdata[COEF_BITS-1:0];
        REG_THRESHOLD: thresh_q  <= pwdata[THR_BITS-1:0];
        REG_GATE:      gate_q    <= pwdata[SAMPLE_BITS-1:0];
        REG_COOLDOWN:  cool_q    <= pwdata[COOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ATTACK:    prdata = APB_DATA_BITS'(attack_q);
      REG_RELEASE:   prdata = APB_DATA_BITS'(release_q);
      REG_THRESHOLD: prdata = APB_DATA_BITS'(thresh_q);
      REG_GATE:      prdata = APB_DATA_BITS'(gate_q);
      REG_COOLDOWN:  prdata = APB_DATA_BITS'(cool_q);
      default:       prdata = '0;
    endcase
  end

  // shared multiplier
  assign mul_req.en = (state_q == ST_MUL1) || (state_q == ST_MUL2);
  assign mul_req.a  = opa_q;
  assign mul_req.b  = opb_q;

  atod_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // datapath
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mag        = sample_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_i)
                                              : SAMPLE_BITS'(sample_i);
  assign peak_new   = (mag > peak_q) ? mag : peak_q;
  assign p_val      = ENV_BITS'(peak_q) << ENV_SHIFT;
  assign rounded    = prod + ROUND_HALF;
  assign shifted    = rounded >>> COEF_BITS;
  assign env_new    = shifted[ENV_BITS-1:0] + p_val;
  assign onset_gap  = frame_cnt_q - last_onset_q;
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign onset      = ($unsigned(prod) < MUL_RES_BITS'({p_val, THR_FRAC'(0)}))
                   && (peak_q > gate_q)
                   && ((onset_gap > ENV_BITS'(cool_q)) || !seen_q);

  always_comb begin
    state_d      = state_q;
    peak_d       = peak_q;
    env_d        = env_q;
    frame_cnt_d  = frame_cnt_q;
    last_onset_d = last_onset_q;
    seen_d       = seen_q;
    opa_d        = opa_q;
    opb_d        = opb_q;
    out_valid_d  = out_valid_q && out_stall_i;
    trigger_d    = trigger_q;
    idx_out_d    = idx_out_q;
    env_out_d    = env_out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          peak_d = peak_new;
          if (frame_end_i) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        opa_d   = $signed({1'b0, env_q}) - $signed({1'b0, p_val});
        opb_d   = $signed({1'b0, ENV_BITS'((p_val > env_q) ? attack_q : release_q)});
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        state_d = ST_ENV;
      end
      ST_ENV: begin
        env_d   = env_new;
        opa_d   = $signed({1'b0, env_new});
        opb_d   = $signed({1'b0, ENV_BITS'(thresh_q)});
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          trigger_d   = onset;
          idx_out_d   = frame_cnt_q;
          env_out_d   = env_q;
          if (onset) begin
            last_onset_d = frame_cnt_q;
            seen_d       = 1'b1;
          end
          if (frame_cnt_q != '1) begin
            frame_cnt_d = frame_cnt_q + ENV_BITS'(1);
          end
          peak_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      peak_q       <= '0;
      env_q        <= '0;
      frame_cnt_q  <= '0;
      last_onset_q <= '0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      peak_q       <= peak_d;
      env_q        <= env_d;
      frame_cnt_q  <= frame_cnt_d;
      last_onset_q <= last_onset_d;
      seen_q       <= seen_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q     <= opa_d;
    opb_q     <= opb_d;
    trigger_q <= trigger_d;
    idx_out_q <= idx_out_d;
    env_out_q <= env_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign trigger_o        = trigger_q;
  assign frame_index_o    = idx_out_q;
  assign envelope_level_o = env_out_q;

`ifndef SYNTH
  a_result_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DECIDE))
    else $error("result appeared outside the decide step");

  a_trigger_sets_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && trigger_q) |-> seen_q)
    else $error("trigger reported without onset flag");

  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && can_emit) |=>
      (frame_cnt_q == $past(frame_cnt_q) + ENV_BITS'(1)) || ($past(frame_cnt_q) == '1))
    else $error("frame counter did not advance");

  a_peak_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && can_emit) |=> (peak_q == '0))
    else $error("frame peak not cleared at frame end");
`endif

endmodule

/* dv/audio_transient_onset_detector_test.sv */
// self-checking testbench of the audio transient onset detector: random samples against a predictor
`timescale 1ns / 100ps

module audio_transient_onset_detector_test
  import atod_pkg::*;
;

  localparam int unsigned SMP_BITS = 24;
  localparam int unsigned NUM_REGS = 5;
  localparam int unsigned ADDR_SLOTS = 1 << (APB_ADDR_BITS - 2);
  localparam int unsigned PHASE_ITEMS = 272;
  localparam int unsigned COEF_BITS_TB = 24;

  typedef struct {
    logic [SMP_BITS-1:0] smp;
    logic                fe;
  } sample_item_t;

  typedef struct {
    logic        trig;
    logic [31:0] idx;
    logic [31:0] env;
  } onset_result_t;

  typedef enum {LVL_QUIET, LVL_LOUD, LVL_FULL, LVL_EXTREME} level_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SMP_BITS-1:0] sample_i = '0;
  logic                       frame_end_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       trigger_o;
  logic [ENV_BITS-1:0]        frame_index_o;
  logic [ENV_BITS-1:0]        envelope_level_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0]   paddr = '0;
  logic [APB_DATA_BITS-1:0]   pwdata = '0;
  logic [APB_DATA_BITS-1:0]   prdata;
  logic                       pready;

  audio_transient_onset_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .trigger_o        (trigger_o),
    .frame_index_o    (frame_index_o),
    .envelope_level_o (envelope_level_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of registers and state
  logic [23:0] attack_g, release_g, thr_gain, gate_lvl, cool_frames;
  logic [23:0] peak_q;
  logic [31:0] env_q, frame_cnt, last_onset;
  logic        onset_seen;

  sample_item_t  pending_items[$];
  onset_result_t expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned onsets_seen = 0;
  int unsigned settings_used = 0;
  bit          steady = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at %0t: got %0h, want %0h", what, $time, got, want);
    mismatch_count++;
  endtask

  task automatic predict_frame_result(input logic [SMP_BITS-1:0] smp, input logic fe);
    logic [23:0]   mag, pk;
    logic [63:0]   p, e, g, acc, e_new;
    logic [31:0]   onset_gap;
    onset_result_t r;
    mag = smp[SMP_BITS-1] ? (24'd0 - smp) : smp;
    pk = (mag > peak_q) ? mag : peak_q;
    if (!fe) begin
      peak_q = pk;
    end else begin
      p = {32'd0, pk, 8'd0};
      e = {32'd0, env_q};
      g = (p > e) ? {40'd0, attack_g} : {40'd0, release_g};
      acc = p * ((64'd1 << COEF_BITS_TB) - g) + e * g + (64'd1 << (COEF_BITS_TB - 1));
      e_new = acc >> COEF_BITS_TB;
      env_q = e_new[31:0];
      r.trig = 1'b0;
      r.idx = frame_cnt;
      onset_gap = frame_cnt - last_onset;
      if ((p << 16) > e_new * {40'd0, thr_gain} && pk > gate_lvl &&
          (onset_gap > {8'd0, cool_frames} || !onset_seen)) begin
        r.trig = 1'b1;
        last_onset = frame_cnt;
        onset_seen = 1'b1;
      end
      if (frame_cnt != 32'hFFFF_FFFF) frame_cnt = frame_cnt + 1;
      peak_q = '0;
      r.env = env_q;
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    sample_item_t nxt;
    if (in_valid_i && !in_stall_o) begin
      predict_frame_result(sample_i, frame_end_i);
      items_sent++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (rst_ni && pending_items.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
        nxt = pending_items.pop_front();
        in_valid_i <= 1'b1;
        sample_i <= nxt.smp;
        frame_end_i <= nxt.fe;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    onset_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (trigger_o) onsets_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", frame_index_o, '0);
      end else begin
        want = expected_results.pop_front();
        if (trigger_o !== want.trig)
          report_mismatch("trigger", 32'(trigger_o), 32'(want.trig));
        if (frame_index_o !== want.idx) report_mismatch("frame_index", frame_index_o, want.idx);
        if (envelope_level_o !== want.env)
          report_mismatch("envelope_level", envelope_level_o, want.env);
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < 8);
  end

  task automatic write_register(input int unsigned idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_BITS'(idx * 4);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ATTACK:    attack_g = value[23:0];
      REG_RELEASE:   release_g = value[23:0];
      REG_THRESHOLD: thr_gain = value[23:0];
      REG_GATE:      gate_lvl = value[23:0];
      REG_COOLDOWN:  cool_frames = value[23:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic push_item(input logic [SMP_BITS-1:0] smp, input logic fe);
    sample_item_t it;
    it.smp = smp;
    it.fe = fe;
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [SMP_BITS-1:0] pick_sample(input level_e lvl);
    logic [SMP_BITS-1:0] m;
    case (lvl)
      LVL_QUIET: m = SMP_BITS'($urandom_range(0, 2000));
      LVL_LOUD:  m = SMP_BITS'($urandom_range(24'h100000, 24'h7FFFFF));
      LVL_FULL:  return SMP_BITS'($urandom());
      default: begin
        case ($urandom_range(3))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          default: return 24'hFFFFFF;
        endcase
      end
    endcase
    return $urandom_range(1) ? (24'd0 - m) : m;
  endfunction

  task automatic push_frame(input int unsigned n, input level_e lvl);
    for (int unsigned i = 0; i < n; i++) push_item(pick_sample(lvl), i == n - 1);
  endtask

  task automatic push_random_frames(input int unsigned budget);
    int unsigned used, n, r;
    level_e      lvl;
    used = 0;
    while (used < budget) begin
      r = $urandom_range(99);
      lvl = (r < 50) ? LVL_QUIET : (r < 65) ? LVL_LOUD : (r < 90) ? LVL_FULL : LVL_EXTREME;
      if ($urandom_range(19) == 0) begin
        // stray sample that merges into the following frame
        push_item(pick_sample(LVL_FULL), 1'b0);
        used++;
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      push_frame(n, lvl);
      used += n;
    end
  endtask

  task automatic write_random_setting();
    logic [31:0] hi;
    hi = $urandom() & 32'hFF00_0000;
    write_register(REG_ATTACK, hi | ($urandom_range(1) ? $urandom_range(0, 24'hFFFFFF)
                                     : $urandom_range(24'hF00000, 24'hFFFFFF)));
    write_register(REG_RELEASE, ($urandom() & 32'hFF00_0000) |
                   ($urandom_range(1) ? $urandom_range(0, 24'hFFFFFF)
                    : $urandom_range(24'hF00000, 24'hFFFFFF)));
    write_register(REG_THRESHOLD, ($urandom() & 32'hFF00_0000) |
                   $urandom_range(24'h008000, 24'h060000));
    write_register(REG_GATE, $urandom_range(0, 24'h020000));
    write_register(REG_COOLDOWN, ($urandom_range(3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                          : $urandom_range(0, 16));
    settings_used++;
  endtask

  initial begin
    #5_000_000;
    $display("timeout at %0t", $time);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    attack_g = ATTACK_RST[23:0];
    release_g = RELEASE_RST[23:0];
    thr_gain = THRESHOLD_RST[23:0];
    gate_lvl = GATE_RST[23:0];
    cool_frames = COOLDOWN_RST[23:0];
    peak_q = '0;
    env_q = '0;
    frame_cnt = '0;
    last_onset = '0;
    onset_seen = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: single-item frames, extremes, onset then cooldown hold
    settings_used++;
    push_item(24'h000000, 1'b1);
    push_item(24'h7FFFFF, 1'b1);
    push_item(24'h800000, 1'b1);
    push_item(24'hFFFFFF, 1'b0);
    push_item(24'h000001, 1'b0);
    push_item(24'h800000, 1'b0);
    push_item(24'h7FFFFF, 1'b1);
    for (int i = 0; i < 5; i++) push_frame(2, LVL_QUIET);
    push_frame(3, LVL_LOUD);
    push_frame(1, LVL_EXTREME);
    wait_idle();

    // zero coefficients and thresholds, plus writes to unmapped slots
    write_register(REG_ATTACK, 32'd0);
    write_register(REG_RELEASE, 32'd0);
    write_register(REG_THRESHOLD, 32'd0);
    write_register(REG_GATE, 32'd0);
    write_register(REG_COOLDOWN, 32'd0);
    for (int unsigned k = NUM_REGS; k < ADDR_SLOTS; k++) write_register(k, $urandom());
    settings_used++;
    push_item(24'h000001, 1'b1);
    push_item(24'h800000, 1'b1);
    push_item(24'h000000, 1'b1);
    push_random_frames(PHASE_ITEMS);
    wait_idle();

    // all ones with dropped upper bits, gate at its ceiling
    for (int unsigned k = 0; k < NUM_REGS; k++) write_register(k, 32'hFFFF_FFFF);
    write_register(REG_GATE, 32'd8388608);
    settings_used++;
    push_random_frames(PHASE_ITEMS);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_random_setting();
      steady = (ph == 2);
      push_random_frames(PHASE_ITEMS);
      wait_idle();
      steady = 1'b0;
    end

    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    $display("covered %0d samples over %0d register settings", items_sent, settings_used);
    $display("checked %0d frame results, %0d of them onsets", results_seen, onsets_seen);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/atod_pkg.sv
design/atod_mul.sv
design/audio_transient_onset_detector.sv
dv/audio_transient_onset_detector_test.sv
